### src/apahv_pkg.sv
// apahv_pkg: shared constants and result type for the disk header validator
// no dependencies; imported by every module of the block
package apahv_pkg;

	// header geometry
	localparam int unsigned POS_W = 10;
	localparam logic [POS_W-1:0] HDR_LAST = 10'h3FF;
	localparam logic [POS_W-1:0] MAGIC_AT = 10'h004;
	localparam logic [POS_W-1:0] ID_AT = 10'h010;
	localparam logic [POS_W-1:0] VENDOR_AT = 10'h100;
	localparam logic [POS_W-1:0] CSUM_END = 10'h003;
	localparam logic [POS_W-1:0] BOOT_START_END = 10'h133;
	localparam logic [POS_W-1:0] BOOT_LEN_END = 10'h137;
	localparam logic [POS_W-1:0] SIG_AT = 10'h1FE;
	localparam logic [POS_W-1:0] SIG_HI_AT = 10'h1FF;

	// string lengths
	localparam int unsigned MAGIC_LEN = 4;
	localparam int unsigned ID_LEN = 5;
	localparam int unsigned VENDOR_LEN = 32;

	// constant strings, byte zero in the lowest bits
	localparam logic [8*MAGIC_LEN-1:0] MAGIC_BYTES = 32'h0041_5041;
	localparam logic [8*ID_LEN-1:0] ID_BYTES = 40'h72_626D_5F5F;
	localparam logic [8*VENDOR_LEN-1:0] VENDOR_BYTES =
		256'h2E636E49_20746E65_6D6E6961_74726574_6E452072_65747570_6D6F4320_796E6F53;

	// signature bytes
	localparam logic [7:0] SIG_LO = 8'h55;
	localparam logic [7:0] SIG_HI = 8'hAA;

	// match flag bit positions
	localparam int unsigned FLAG_MAGIC = 0;
	localparam int unsigned FLAG_ID = 1;
	localparam int unsigned FLAG_VENDOR = 2;

	// one result item, header_valid in the lowest bit
	typedef struct packed {
		logic        pad;
		logic        hybrid_layout;
		logic        boot_enabled;
		logic [31:0] boot_length;
		logic [31:0] boot_start;
		logic [31:0] stored_sum;
		logic [31:0] computed_sum;
		logic        checksum_ok;
		logic        vendor_ok;
		logic        id_ok;
		logic        magic_ok;
		logic        header_valid;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

endpackage

### src/apahv_tracker.sv
// apahv_tracker: byte position, word assembly, checksum and string checks
// depends on apahv_pkg; builds the result item on the last header byte
module apahv_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           data_byte,
	input  logic                 start_of_header,
	output logic                 emit,
	output apahv_pkg::result_t   result
);
	import apahv_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [23:0]      word_q;
	logic [31:0]      sum_q;
	logic [31:0]      csum_q;
	logic [2:0]       flags_q;
	logic [31:0]      boot_start_q;
	logic [31:0]      boot_len_q;
	logic [7:0]       sig_low_q;
	logic             sig_match_q;

	logic [POS_W-1:0] pos_e;
	logic [23:0]      word_e;
	logic [31:0]      sum_e;
	logic [31:0]      csum_e;
	logic [2:0]       flags_e;
	logic [31:0]      boot_start_e;
	logic [31:0]      boot_len_e;
	logic [7:0]       sig_low_e;
	logic             sig_match_e;

	logic [23:0]      word_n;
	logic [31:0]      sum_n;
	logic [31:0]      csum_n;
	logic [2:0]       flags_n;
	logic [31:0]      boot_start_n;
	logic [31:0]      boot_len_n;
	logic [7:0]       sig_low_n;
	logic             sig_match_n;
	logic [31:0]      full_word;
	logic [POS_W-1:0] id_off;
	logic             last;

	// a start flag restarts everything before the byte is used
	always_comb begin
		if (start_of_header) begin
			pos_e        = '0;
			word_e       = '0;
			sum_e        = '0;
			csum_e       = '0;
			flags_e      = '1;
			boot_start_e = '0;
			boot_len_e   = '0;
			sig_low_e    = '0;
			sig_match_e  = 1'b0;
		end else begin
			pos_e        = pos_q;
			word_e       = word_q;
			sum_e        = sum_q;
			csum_e       = csum_q;
			flags_e      = flags_q;
			boot_start_e = boot_start_q;
			boot_len_e   = boot_len_q;
			sig_low_e    = sig_low_q;
			sig_match_e  = sig_match_q;
		end
	end

	// string compares against the constant tables
	always_comb begin
		flags_n = flags_e;
		id_off  = pos_e - ID_AT;
		if (pos_e[POS_W-1:2] == MAGIC_AT[POS_W-1:2] &&
		    MAGIC_BYTES[8*pos_e[1:0] +: 8] != data_byte)
			flags_n[FLAG_MAGIC] = 1'b0;
		if (pos_e >= ID_AT && id_off < POS_W'(ID_LEN) &&
		    ID_BYTES[8*id_off[2:0] +: 8] != data_byte)
			flags_n[FLAG_ID] = 1'b0;
		if (pos_e[POS_W-1:5] == VENDOR_AT[POS_W-1:5] &&
		    VENDOR_BYTES[8*pos_e[4:0] +: 8] != data_byte)
			flags_n[FLAG_VENDOR] = 1'b0;
	end

	// little-endian word assembly, sum and field captures
	always_comb begin
		word_n       = word_e;
		sum_n        = sum_e;
		csum_n       = csum_e;
		boot_start_n = boot_start_e;
		boot_len_n   = boot_len_e;
		sig_low_n    = sig_low_e;
		sig_match_n  = sig_match_e;
		full_word    = {data_byte, word_e};
		case (pos_e[1:0])
			2'd0: word_n = {16'h0000, data_byte};
			2'd1: word_n = {word_e[23:16], data_byte, word_e[7:0]};
			2'd2: word_n = {data_byte, word_e[15:0]};
			default: begin
				word_n = '0;
				if (pos_e == CSUM_END)
					csum_n = full_word;
				else
					sum_n = sum_e + full_word;
				if (pos_e == BOOT_START_END)
					boot_start_n = full_word;
				if (pos_e == BOOT_LEN_END)
					boot_len_n = full_word;
			end
		endcase
		if (pos_e == SIG_AT)
			sig_low_n = data_byte;
		if (pos_e == SIG_HI_AT)
			sig_match_n = (sig_low_e == SIG_LO) && (data_byte == SIG_HI);
	end

	// result item for the last byte
	assign last = (pos_e == HDR_LAST);
	assign emit = last;

	always_comb begin
		result               = '0;
		result.magic_ok      = flags_n[FLAG_MAGIC];
		result.id_ok         = flags_n[FLAG_ID];
		result.vendor_ok     = flags_n[FLAG_VENDOR];
		result.checksum_ok   = (csum_n == sum_n);
		result.header_valid  = (&flags_n) && (csum_n == sum_n);
		result.computed_sum  = sum_n;
		result.stored_sum    = csum_n;
		result.boot_start    = boot_start_n;
		result.boot_length   = boot_len_n;
		result.boot_enabled  = (boot_start_n != '0) || (boot_len_n != '0);
		result.hybrid_layout = sig_match_n;
	end

	// state registers; position, word, sum and flags are rearmed after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			word_q       <= '0;
			sum_q        <= '0;
			csum_q       <= '0;
			flags_q      <= '1;
			boot_start_q <= '0;
			boot_len_q   <= '0;
			sig_low_q    <= '0;
			sig_match_q  <= 1'b0;
		end else if (fire) begin
			csum_q       <= csum_n;
			boot_start_q <= boot_start_n;
			boot_len_q   <= boot_len_n;
			sig_low_q    <= sig_low_n;
			sig_match_q  <= sig_match_n;
			if (last) begin
				pos_q   <= '0;
				word_q  <= '0;
				sum_q   <= '0;
				flags_q <= '1;
			end else begin
				pos_q   <= pos_e + POS_W'(1);
				word_q  <= word_n;
				sum_q   <= sum_n;
				flags_q <= flags_n;
			end
		end
	end

endmodule

### src/apahv_result_reg.sv
// apahv_result_reg: output register holding one result item until taken
// depends on apahv_pkg for the result type
module apahv_result_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  apahv_pkg::result_t   result,
	output logic                 room,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output apahv_pkg::result_t   m_axis_tdata
);
	import apahv_pkg::*;

	logic    valid_q;
	result_t data_q;

	// free when empty or being taken this cycle
	assign room = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

endmodule

### src/apa_header_validator.sv
// apa_header_validator: top level of the streaming disk header validator
// depends on apahv_pkg, apahv_tracker and apahv_result_reg
// throughput: one header byte per cycle, except while a blocked result stalls a last byte
// result tvalid rises once the last header byte has passed the input and result registers
// one result item per 1024 bytes; a blocked result stalls input only at the next last byte
// reset: arst_n asynchronous, clears position to zero, sum and captures to zero,
// match flags to all ones and both valid registers
module apa_header_validator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // data_byte
	input  logic                              s_axis_tuser,  // start_of_header
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// header_valid, magic_ok, id_ok, vendor_ok, checksum_ok, computed_sum[31:0],
	// stored_sum[31:0], boot_start[31:0], boot_length[31:0], boot_enabled,
	// hybrid_layout, one zero pad bit
	output logic [apahv_pkg::RESULT_W-1:0]    m_axis_tdata
);
	import apahv_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       emit;
	logic       room;
	logic       go;
	logic       fire;
	result_t    result;
	result_t    out_data;

	// input register; an item moves on unless its result has nowhere to go
	assign go            = !emit || room;
	assign fire          = valid_s1 && go;
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// header state and checks
	apahv_tracker u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.data_byte       (byte_s1),
		.start_of_header (start_s1),
		.emit            (emit),
		.result          (result)
	);

	// result register
	apahv_result_reg u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire && emit),
		.result        (result),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (out_data)
	);

	assign m_axis_tdata = out_data;

endmodule

### src/apahv_checker.sv
// apahv_checker: port-level assertions for apa_header_validator
// depends on apahv_pkg; attached to the top level by the bind below
module apahv_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [apahv_pkg::RESULT_W-1:0] m_axis_tdata
);
	import apahv_pkg::*;

	result_t r;
	assign r = m_axis_tdata;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// overall validity is the and of the four checks
	a_valid_and: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> r.header_valid ==
			(r.magic_ok && r.id_ok && r.vendor_ok && r.checksum_ok))
		else $error("header_valid disagrees with flags");

	// checksum flag follows the two sums
	a_csum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> r.checksum_ok == (r.computed_sum == r.stored_sum))
		else $error("checksum_ok disagrees with sums");

	// boot flag follows the boot fields
	a_boot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> r.boot_enabled ==
			((r.boot_start != '0) || (r.boot_length != '0)))
		else $error("boot_enabled disagrees with fields");

	// a new result cannot appear without an input item having been taken
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result item with no input item behind it");

endmodule

bind apa_header_validator apahv_checker u_apahv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### test/tb_apa_header_validator.sv
// tb_apa_header_validator: streams whole and broken 1024-byte headers through the validator
// and checks every result item against a byte-level tracker kept in the testbench
// depends on apahv_pkg and apa_header_validator
`timescale 1ns / 100ps

module tb_apa_header_validator;
	import apahv_pkg::*;

	localparam int unsigned CLK_HALF = 4;
	localparam int unsigned HDR_BYTES = 1024;
	localparam int unsigned STALL_CYCLES = 3000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_HEADERS = 40;
	localparam longint unsigned LIMIT_CYCLES = 2_000_000;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;   // data_byte
	logic s_axis_tuser;         // start_of_header
	logic m_axis_tvalid;
	logic m_axis_tready;
	// header_valid, magic_ok, id_ok, vendor_ok, checksum_ok, computed_sum, stored_sum,
	// boot_start, boot_length, boot_enabled, hybrid_layout, pad
	logic [RESULT_W-1:0] m_axis_tdata;

	// header image under construction, byte zero first
	logic [7:0] hdr [0:HDR_BYTES-1];

	// expected result items, oldest first
	result_t pending_reports[$];
	int unsigned fail_count = 0;

	// idle controls for the sender and the sink, and the sink's stall request
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit stall_request = 1'b0;

	// tracker state
	logic [POS_W-1:0] trk_pos;
	logic [23:0] trk_asm;
	logic [31:0] trk_sum;
	logic [31:0] trk_csum;
	logic [31:0] trk_boot_start;
	logic [31:0] trk_boot_len;
	logic [7:0] trk_sig_lo;
	logic trk_sig_ok;
	logic [2:0] trk_flags;

	apa_header_validator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock, 8 ns period
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// per-header re-arm of the tracker
	function automatic void rearm_tracker();
		trk_pos = '0;
		trk_asm = '0;
		trk_sum = '0;
		trk_flags = 3'b111;
	endfunction

	// full clear, as after reset or a start flag
	function automatic void clear_tracker();
		rearm_tracker();
		trk_csum = '0;
		trk_boot_start = '0;
		trk_boot_len = '0;
		trk_sig_lo = '0;
		trk_sig_ok = 1'b0;
	endfunction

	// true when position p lies inside a string window and the byte differs
	function automatic bit byte_differs(logic [POS_W-1:0] p, logic [POS_W-1:0] base,
			int unsigned len, logic [255:0] str, logic [7:0] b);
		int unsigned off;
		if (p < base || p >= base + len)
			return 1'b0;
		off = p - base;
		return str[8*off +: 8] != b;
	endfunction

	// advance the tracker by one accepted item, queue a report at the last byte
	function automatic void track_header_byte(logic [7:0] b, logic sof);
		logic [POS_W-1:0] p;
		logic [1:0] lane;
		logic [31:0] word;
		result_t r;
		if (sof)
			clear_tracker();
		p = trk_pos;
		lane = p[1:0];

		// string windows
		if (byte_differs(p, MAGIC_AT, MAGIC_LEN, 256'(MAGIC_BYTES), b))
			trk_flags[FLAG_MAGIC] = 1'b0;
		if (byte_differs(p, ID_AT, ID_LEN, 256'(ID_BYTES), b))
			trk_flags[FLAG_ID] = 1'b0;
		if (byte_differs(p, VENDOR_AT, VENDOR_LEN, VENDOR_BYTES, b))
			trk_flags[FLAG_VENDOR] = 1'b0;

		// signature
		if (p == SIG_AT)
			trk_sig_lo = b;
		if (p == SIG_HI_AT)
			trk_sig_ok = (trk_sig_lo == SIG_LO) && (b == SIG_HI);

		// word assembly and sum
		if (lane != 2'd3) begin
			if (lane == 2'd0)
				trk_asm = {16'b0, b};
			else
				trk_asm = trk_asm | ({16'b0, b} << (8 * lane));
		end else begin
			word = {b, trk_asm};
			if (p == CSUM_END)
				trk_csum = word;
			else
				trk_sum = trk_sum + word;
			if (p == BOOT_START_END)
				trk_boot_start = word;
			if (p == BOOT_LEN_END)
				trk_boot_len = word;
			trk_asm = '0;
		end

		if (p != HDR_LAST) begin
			trk_pos = p + 1'b1;
			return;
		end

		// last byte: one report
		r = '0;
		r.magic_ok = trk_flags[FLAG_MAGIC];
		r.id_ok = trk_flags[FLAG_ID];
		r.vendor_ok = trk_flags[FLAG_VENDOR];
		r.checksum_ok = (trk_csum == trk_sum);
		r.header_valid = (&trk_flags) && (trk_csum == trk_sum);
		r.computed_sum = trk_sum;
		r.stored_sum = trk_csum;
		r.boot_start = trk_boot_start;
		r.boot_length = trk_boot_len;
		r.boot_enabled = (trk_boot_start != 0) || (trk_boot_len != 0);
		r.hybrid_layout = trk_sig_ok;
		pending_reports.push_back(r);
		rearm_tracker();
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] have);
		if (have !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, have);
			fail_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_reports.size() == 0) begin
				$error("result item with no expectation pending");
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("header_valid", want.header_valid, got.header_valid);
				check_field("magic_ok", want.magic_ok, got.magic_ok);
				check_field("id_ok", want.id_ok, got.id_ok);
				check_field("vendor_ok", want.vendor_ok, got.vendor_ok);
				check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
				check_field("computed_sum", want.computed_sum, got.computed_sum);
				check_field("stored_sum", want.stored_sum, got.stored_sum);
				check_field("boot_start", want.boot_start, got.boot_start);
				check_field("boot_length", want.boot_length, got.boot_length);
				check_field("boot_enabled", want.boot_enabled, got.boot_enabled);
				check_field("hybrid_layout", want.hybrid_layout, got.hybrid_layout);
			end
		end
	end

	// result sink with random idling and an occasional long hold-off
	initial begin : result_sink
		int gap;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_request) begin
				stall_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end
			gap = rx_idle ? $urandom_range(0, 6) : 0;
			repeat (gap) begin
				m_axis_tready <= 1'b0;
				@(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid && !stall_request);
		end
	end

	// send one item, after a random gap when tx_idle is set, track it once accepted
	task automatic send_byte(input logic [7:0] b, input logic sof);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= sof;
		do @(posedge clk); while (!s_axis_tready);
		track_header_byte(b, sof);
	endtask

	task automatic send_header(input bit sof);
		for (int i = 0; i < HDR_BYTES; i++)
			send_byte(hdr[i], sof && (i == 0));
	endtask

	// sender pause until every report is in
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// header image helpers
	function automatic void fill_random();
		for (int i = 0; i < HDR_BYTES; i++)
			hdr[i] = 8'($urandom);
	endfunction

	function automatic void fill_const(logic [7:0] v);
		for (int i = 0; i < HDR_BYTES; i++)
			hdr[i] = v;
	endfunction

	function automatic void place_strings();
		for (int i = 0; i < MAGIC_LEN; i++)
			hdr[MAGIC_AT + i] = MAGIC_BYTES[8*i +: 8];
		for (int i = 0; i < ID_LEN; i++)
			hdr[ID_AT + i] = ID_BYTES[8*i +: 8];
		for (int i = 0; i < VENDOR_LEN; i++)
			hdr[VENDOR_AT + i] = VENDOR_BYTES[8*i +: 8];
	endfunction

	function automatic void set_word(int unsigned at, logic [31:0] w);
		for (int i = 0; i < 4; i++)
			hdr[at + i] = w[8*i +: 8];
	endfunction

	function automatic void set_signature(logic [7:0] lo, logic [7:0] hi);
		hdr[SIG_AT] = lo;
		hdr[SIG_HI_AT] = hi;
	endfunction

	// word zero becomes the sum of words 1 to 255
	function automatic void seal_checksum();
		logic [31:0] s;
		s = '0;
		for (int w = 1; w < HDR_BYTES / 4; w++)
			s = s + {hdr[4*w+3], hdr[4*w+2], hdr[4*w+1], hdr[4*w]};
		set_word(0, s);
	endfunction

	// flip one bit of a string byte, index over all 41 string bytes
	function automatic void corrupt_string_byte(int unsigned k);
		int unsigned at;
		if (k < MAGIC_LEN)
			at = MAGIC_AT + k;
		else if (k < MAGIC_LEN + ID_LEN)
			at = ID_AT + k - MAGIC_LEN;
		else
			at = VENDOR_AT + k - MAGIC_LEN - ID_LEN;
		hdr[at] = hdr[at] ^ (8'h01 << $urandom_range(0, 7));
	endfunction

	// counting from reset, no start flag on the first header
	task automatic test_power_up_alignment();
		fill_random();
		place_strings();
		set_signature(SIG_LO, SIG_HI);
		seal_checksum();
		send_header(1'b0);
	endtask

	task automatic test_good_header();
		fill_random();
		place_strings();
		set_signature(SIG_LO, SIG_HI);
		seal_checksum();
		send_header(1'b1);
	endtask

	// all-zero and all-ones images, with and without strings
	task automatic test_fill_extremes();
		fill_const(8'h00);
		send_header(1'b1);
		fill_const(8'hFF);
		send_header(1'b1);
		fill_const(8'hFF);
		place_strings();
		set_signature(SIG_LO, SIG_HI);
		seal_checksum();
		send_header(1'b1);
		fill_const(8'h00);
		place_strings();
		seal_checksum();
		send_header(1'b1);
	endtask

	// first and last byte of each string wrong, checksum still consistent
	task automatic test_string_faults();
		int unsigned picks [6];
		picks = '{0, MAGIC_LEN - 1, MAGIC_LEN, MAGIC_LEN + ID_LEN - 1,
			MAGIC_LEN + ID_LEN, MAGIC_LEN + ID_LEN + VENDOR_LEN - 1};
		foreach (picks[i]) begin
			fill_random();
			place_strings();
			set_signature(SIG_LO, SIG_HI);
			corrupt_string_byte(picks[i]);
			seal_checksum();
			send_header(1'b1);
		end
	endtask

	// stored word off in the lowest and in the highest bit
	task automatic test_checksum_fault();
		fill_random();
		place_strings();
		seal_checksum();
		hdr[0] = hdr[0] ^ 8'h01;
		send_header(1'b1);
		fill_random();
		place_strings();
		seal_checksum();
		hdr[3] = hdr[3] ^ 8'h80;
		send_header(1'b1);
	endtask

	// signature variants paired with boot field variants
	task automatic test_signature_and_boot();
		fill_random();
		place_strings();
		set_signature(SIG_LO, SIG_HI);
		set_word(BOOT_START_END - 3, 32'h0);
		set_word(BOOT_LEN_END - 3, 32'h0);
		seal_checksum();
		send_header(1'b1);
		fill_random();
		place_strings();
		set_signature(SIG_LO, 8'h00);
		set_word(BOOT_START_END - 3, 32'h0000_0001);
		set_word(BOOT_LEN_END - 3, 32'h0);
		seal_checksum();
		send_header(1'b1);
		fill_random();
		place_strings();
		set_signature(8'h00, SIG_HI);
		set_word(BOOT_START_END - 3, 32'h0);
		set_word(BOOT_LEN_END - 3, 32'h8000_0000);
		seal_checksum();
		send_header(1'b1);
		fill_random();
		place_strings();
		set_signature(SIG_HI, SIG_LO);
		set_word(BOOT_START_END - 3, 32'hFFFF_FFFF);
		set_word(BOOT_LEN_END - 3, 32'hFFFF_FFFF);
		seal_checksum();
		send_header(1'b1);
	endtask

	// start flag inside a header abandons it, including at the would-be last byte
	task automatic test_restart_mid_header();
		fill_random();
		for (int i = 0; i < 300; i++)
			send_byte(hdr[i], i == 0);
		place_strings();
		set_signature(SIG_LO, SIG_HI);
		seal_checksum();
		send_header(1'b1);
		fill_random();
		for (int i = 0; i < HDR_BYTES - 1; i++)
			send_byte(hdr[i], 1'b0);
		place_strings();
		seal_checksum();
		send_header(1'b1);
		send_byte(8'hA5, 1'b1);
		send_header(1'b1);
	endtask

	// headers back to back with no start flag and no idling
	task automatic test_back_to_back();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (3) begin
			fill_random();
			place_strings();
			set_signature(SIG_LO, SIG_HI);
			seal_checksum();
			send_header(1'b0);
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// sink holds off long enough that the input stalls at a last byte
	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		stall_request = 1'b1;
		repeat (3) begin
			fill_random();
			place_strings();
			set_signature(SIG_LO, SIG_HI);
			seal_checksum();
			send_header(1'b1);
		end
		wait_drained();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// mostly well-formed headers with random content, some faults and some noise
	task automatic test_random_headers();
		bit need_sof;
		int unsigned cnt;
		int unsigned pick;
		need_sof = 1'b1;
		for (int n = 0; n < RANDOM_HEADERS; n++) begin
			tx_idle = $urandom_range(0, 9) < 7;
			rx_idle = $urandom_range(0, 9) < 7;

			// noise: random bytes with the odd start flag
			if ($urandom_range(0, 6) == 0) begin
				cnt = $urandom_range(1, HDR_BYTES - 1);
				for (int i = 0; i < cnt; i++)
					send_byte(8'($urandom), $urandom_range(0, 15) == 0);
				need_sof = 1'b1;
			end

			case ($urandom_range(0, 9))
				0: fill_const(8'h00);
				1: fill_const(8'hFF);
				default: fill_random();
			endcase
			if ($urandom_range(0, 6) != 0)
				place_strings();
			if ($urandom_range(0, 3) == 0)
				corrupt_string_byte($urandom_range(0, MAGIC_LEN + ID_LEN + VENDOR_LEN - 1));
			case ($urandom_range(0, 3))
				0, 1: set_signature(SIG_LO, SIG_HI);
				2: set_signature(SIG_LO, 8'($urandom));
				default: ;
			endcase
			case ($urandom_range(0, 2))
				0: begin
					set_word(BOOT_START_END - 3, 32'h0);
					set_word(BOOT_LEN_END - 3, 32'h0);
				end
				1: set_word($urandom_range(0, 1) ? BOOT_START_END - 3 : BOOT_LEN_END - 3, 32'h0);
				default: ;
			endcase
			if ($urandom_range(0, 5) != 0) begin
				seal_checksum();
			end else if ($urandom_range(0, 1)) begin
				seal_checksum();
				pick = $urandom_range(0, 3);
				hdr[pick] = hdr[pick] ^ (8'h01 << $urandom_range(0, 7));
			end
			send_header(need_sof || ($urandom_range(0, 3) == 0));
			need_sof = 1'b0;
		end
	endtask

	// main sequence
	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		clear_tracker();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_alignment();
		test_good_header();
		test_fill_extremes();
		test_string_faults();
		test_checksum_fault();
		test_signature_and_boot();
		test_restart_mid_header();
		test_back_to_back();
		test_output_backpressure();
		test_random_headers();

		wait_drained();
		if (fail_count == 0)
			$display("apa_header_validator verification clean");
		else
			$display("apa_header_validator verification failed");
		$finish;
	end

	// run limit
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("apa_header_validator verification failed");
		$finish;
	end

endmodule
